// ===== hdl/vrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types and constants of the voxel ray traversal block.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture the ray on input transfer
    logic       setup;     // compute start voxels and load the dividers
    logic       div_run;   // one quotient bit per divider
    logic       init;      // take the distances from the dividers
    logic       step;      // walk one voxel into the output register
    logic [6:0] step_idx;
    logic       last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;        // output register can take a result this cycle
  } sts_t;

endpackage

// ===== hdl/vrt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_div
// Restoring unsigned divider, one quotient bit per cycle while run_i is high.
// ----------------------------------------------------------------------------
module vrt_div #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 16
) (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             run_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   trial;

  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    rem_d = rem_q;
    quo_d = quo_q;
    if (load_i) begin
      rem_d = '0;
      quo_d = num_i;
    end else if (run_i) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (load_i) begin
      den_q <= den_i;
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== hdl/vrt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_datapath
// Ray registers, start voxel setup, six dividers, step logic and output register.
// ----------------------------------------------------------------------------
module vrt_datapath #(
  parameter int ORIGIN_FRAC_BITS = 8,
  parameter int DIR_FRAC_BITS    = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vrt_pkg::cmd_t      cmd_i,
  output vrt_pkg::sts_t      sts_o,
  input  logic signed [23:0] origin_x_i,
  input  logic signed [23:0] origin_y_i,
  input  logic signed [23:0] origin_z_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] voxel_x_o,
  output logic signed [15:0] voxel_y_o,
  output logic signed [15:0] voxel_z_o,
  output logic [1:0]         normal_axis_o,
  output logic               normal_negative_o,
  output logic [6:0]         step_index_o,
  output logic               last_o
);

  localparam int F     = ORIGIN_FRAC_BITS;
  localparam int NUM_W = 17 + DIR_FRAC_BITS;
  localparam int SHL   = 16 + DIR_FRAC_BITS - F;

  logic signed [23:0] org_q [3];
  logic signed [15:0] dir_q [3];
  logic signed [15:0] vox_q [3];
  logic               neg_q [3];
  logic               zero_q [3];
  logic [31:0]        tmax_q [3];
  logic [31:0]        tdel_q [3];

  logic [NUM_W-1:0] num_max [3];
  logic [NUM_W-1:0] num_del [3];
  logic [15:0]      ad [3];
  logic [NUM_W-1:0] quo_max [3];
  logic [NUM_W-1:0] quo_del [3];
  logic signed [15:0] vox_init [3];

  // start voxel and face distance per axis
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [23:0]        mag;
    logic [24:0]        rsum;
    logic [24:0]        rmask;
    logic signed [26:0] vone;
    logic signed [26:0] face_s;
    logic [15:0]        r16;

    always_comb begin
      mag   = org_q[a][23] ? 24'(-org_q[a]) : 24'(org_q[a]);
      rsum  = {1'b0, mag} + 25'(1 << (F - 1));
      rmask = rsum & ~25'((1 << F) - 1);
      r16   = 16'(rsum >> F);
      vone  = org_q[a][23] ? -$signed({2'b00, rmask}) : $signed({2'b00, rmask});
      if (dir_q[a] > 16'sd0) begin
        face_s = vone + 27'sd0 + 27'(1 << (F - 1)) - 27'(org_q[a]);
      end else begin
        face_s = 27'(org_q[a]) - vone + 27'(1 << (F - 1));
      end
      if (face_s < 27'sd0) begin
        face_s = '0;
      end
      num_max[a]  = NUM_W'(face_s[F:0]) << SHL;
      num_del[a]  = NUM_W'(1) << (NUM_W - 1);
      ad[a]       = dir_q[a][15] ? 16'(-dir_q[a]) : 16'(dir_q[a]);
      vox_init[a] = org_q[a][23] ? -$signed(r16) : $signed(r16);
    end

    vrt_div #(.NUM_W(NUM_W), .DEN_W(16)) u_div_max (
      .clk_i (clk_i),
      .load_i(cmd_i.setup),
      .run_i (cmd_i.div_run),
      .num_i (num_max[a]),
      .den_i (ad[a]),
      .quo_o (quo_max[a])
    );

    vrt_div #(.NUM_W(NUM_W), .DEN_W(16)) u_div_del (
      .clk_i (clk_i),
      .load_i(cmd_i.setup),
      .run_i (cmd_i.div_run),
      .num_i (num_del[a]),
      .den_i (ad[a]),
      .quo_o (quo_del[a])
    );
  end

  function automatic logic [31:0] sat_q(input logic [NUM_W-1:0] q);
    logic [63:0] ext;
    ext = 64'(q);
    return (ext > 64'(vrt_pkg::DIST_MAX)) ? vrt_pkg::DIST_MAX : 32'(q);
  endfunction

  // axis choice, ties to z then y
  logic [1:0]  ax;
  logic [32:0] tsum;
  always_comb begin
    if (tmax_q[0] < tmax_q[1]) begin
      ax = (tmax_q[0] < tmax_q[2]) ? vrt_pkg::AXIS_X : vrt_pkg::AXIS_Z;
    end else begin
      ax = (tmax_q[1] < tmax_q[2]) ? vrt_pkg::AXIS_Y : vrt_pkg::AXIS_Z;
    end
    tsum = {1'b0, tmax_q[ax]} + {1'b0, tdel_q[ax]};
  end

  logic signed [15:0] vox_nx [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      vox_nx[a] = vox_q[a];
    end
    vox_nx[ax] = neg_q[ax] ? vox_q[ax] - 16'sd1 : vox_q[ax] + 16'sd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      org_q[0] <= origin_x_i;
      org_q[1] <= origin_y_i;
      org_q[2] <= origin_z_i;
      dir_q[0] <= dir_x_i;
      dir_q[1] <= dir_y_i;
      dir_q[2] <= dir_z_i;
    end
    if (cmd_i.setup) begin
      for (int a = 0; a < 3; a++) begin
        vox_q[a]  <= vox_init[a];
        neg_q[a]  <= !(dir_q[a] > 16'sd0);
        zero_q[a] <= (dir_q[a] == 16'sd0);
      end
    end
    if (cmd_i.init) begin
      for (int a = 0; a < 3; a++) begin
        tmax_q[a] <= zero_q[a] ? vrt_pkg::DIST_MAX : sat_q(quo_max[a]);
        tdel_q[a] <= zero_q[a] ? vrt_pkg::DIST_MAX : sat_q(quo_del[a]);
      end
    end
    if (cmd_i.step) begin
      for (int a = 0; a < 3; a++) begin
        vox_q[a] <= vox_nx[a];
      end
      tmax_q[ax] <= tsum[32] ? vrt_pkg::DIST_MAX : tsum[31:0];
      voxel_x_o         <= vox_nx[0];
      voxel_y_o         <= vox_nx[1];
      voxel_z_o         <= vox_nx[2];
      normal_axis_o     <= ax;
      normal_negative_o <= !neg_q[ax];
      step_index_o      <= cmd_i.step_idx;
      last_o            <= cmd_i.last;
    end
  end

  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== hdl/vrt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_ctrl
// Sequencer: ray transfer, setup, division, walk over the step count.
// ----------------------------------------------------------------------------
module vrt_ctrl #(
  parameter int MAX_STEPS = 64,
  parameter int DIV_STEPS = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [6:0]    step_count_i,
  input  vrt_pkg::sts_t sts_i,
  output vrt_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_INIT  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;

  localparam int DW = $clog2(DIV_STEPS + 1);

  logic [2:0]    state_q, state_d;
  logic [6:0]    cnt_q, cnt_d, k_q, k_d;
  logic [DW-1:0] div_q, div_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    div_d      = div_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.step_idx = k_q;
    cmd_o.last     = (k_q == cnt_q);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d = (step_count_i > 7'(MAX_STEPS)) ? 7'(MAX_STEPS) : step_count_i;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        div_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_run = 1'b1;
        div_d = div_q + DW'(1);
        if (div_q == DW'(DIV_STEPS - 1)) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        k_d     = 7'd1;
        state_d = (cnt_q == 7'd0) ? ST_IDLE : ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          k_d = k_q + 7'd1;
          if (k_q == cnt_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      div_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      div_q   <= div_d;
    end
  end

endmodule

// ===== hdl/voxel_ray_traversal_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_traversal_top
// Fixed point 3D grid walk: one ray in, one result per voxel entered out.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid_i/in_ready_o  | origin xyz Q16.8, dir xyz Q2.14, step_count
//  out     | out_valid_o/out_ready_i| voxel xyz, normal axis/sign, step_index, last
//
// a ray goes through transfer, setup, the bit-serial dividers (one quotient bit a
// cycle, six dividers in parallel), loading of the distances, then one voxel a
// cycle while the output does not stall
// in ready only while idle; the last result may still wait in the output register
// an output stall holds the walk, nothing is dropped
// reset clears the sequencer and output valid only
module voxel_ray_traversal_top #(
  parameter int MAX_STEPS        = 64,
  parameter int ORIGIN_FRAC_BITS = 8,
  parameter int DIR_FRAC_BITS    = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] origin_x_i,
  input  logic signed [23:0] origin_y_i,
  input  logic signed [23:0] origin_z_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  logic [6:0]         step_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] voxel_x_o,
  output logic signed [15:0] voxel_y_o,
  output logic signed [15:0] voxel_z_o,
  output logic [1:0]         normal_axis_o,
  output logic               normal_negative_o,
  output logic [6:0]         step_index_o,
  output logic               last_o
);

  // dividend is 2^(16+D) at most, so this many quotient bits
  localparam int DIV_STEPS = 17 + DIR_FRAC_BITS;

  vrt_pkg::cmd_t cmd;
  vrt_pkg::sts_t sts;

  vrt_ctrl #(
    .MAX_STEPS(MAX_STEPS),
    .DIV_STEPS(DIV_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .step_count_i(step_count_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vrt_datapath #(
    .ORIGIN_FRAC_BITS(ORIGIN_FRAC_BITS),
    .DIR_FRAC_BITS   (DIR_FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .origin_x_i       (origin_x_i),
    .origin_y_i       (origin_y_i),
    .origin_z_i       (origin_z_i),
    .dir_x_i          (dir_x_i),
    .dir_y_i          (dir_y_i),
    .dir_z_i          (dir_z_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .voxel_x_o        (voxel_x_o),
    .voxel_y_o        (voxel_y_o),
    .voxel_z_o        (voxel_z_o),
    .normal_axis_o    (normal_axis_o),
    .normal_negative_o(normal_negative_o),
    .step_index_o     (step_index_o),
    .last_o           (last_o)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the voxel ray traversal block. A queue of rays
// feeds a clocked driver. A clocked monitor compares every voxel result with
// a behavioral grid walk. Both channels see random idle and stall cycles.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_STEPS  = 64;
  localparam int OFRAC      = 8;
  localparam int DFRAC      = 14;
  localparam int N_RANDOM   = 190;
  localparam int STALL_LIM  = 20000;
  localparam logic [63:0] DMAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic signed [23:0] ox, oy, oz;
    logic signed [15:0] dx, dy, dz;
    logic [6:0]         cnt;
  } ray_t;

  typedef struct packed {
    logic signed [15:0] vx, vy, vz;
    logic [1:0]         axis;
    logic               neg;
    logic [6:0]         idx;
    logic               last;
  } voxel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ray_t cur = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  voxel_t got;

  ray_t   ray_q[$];
  voxel_t walk_q[$];
  int     errors = 0;
  int     n_rays = 0;
  int     n_voxels = 0;
  int     idle_cnt = 0;
  bit     quiet = 1'b0;      // stretch with no idling on either side
  bit     drain_hold = 1'b0; // sender waits for the pipe to empty
  bit     stim_done = 1'b0;
  bit     in_fire = 1'b0;    // input transfer seen at the last rising edge

  always #2 clk = ~clk;

  voxel_ray_traversal_top u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .origin_x_i(cur.ox), .origin_y_i(cur.oy), .origin_z_i(cur.oz),
    .dir_x_i(cur.dx), .dir_y_i(cur.dy), .dir_z_i(cur.dz),
    .step_count_i(cur.cnt),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .voxel_x_o(got.vx), .voxel_y_o(got.vy), .voxel_z_o(got.vz),
    .normal_axis_o(got.axis), .normal_negative_o(got.neg),
    .step_index_o(got.idx), .last_o(got.last)
  );

  // start voxel, step sign and the two distances of one axis
  task automatic axis_start(input logic signed [23:0] o, input logic signed [15:0] d,
                            output longint v, output int s,
                            output logic [63:0] tm, output logic [63:0] td);
    longint one, half, mag, r, face;
    logic [63:0] ad;
    one  = 64'sd1 << OFRAC;
    half = one >>> 1;
    mag  = (o < 0) ? -longint'(o) : longint'(o);
    r    = (mag + half) >>> OFRAC;
    v    = (o < 0) ? -r : r;
    s    = (d > 0) ? 1 : -1;
    if (d > 0) face = v * one + half - o;
    else       face = o - (v * one - half);
    if (face < 0) face = 0;
    if (d == 0) begin
      tm = DMAX;
      td = DMAX;
    end else begin
      ad = (d < 0) ? -longint'(d) : longint'(d);
      tm = (64'(face) << (16 + DFRAC)) / (ad << OFRAC);
      td = (64'd1 << (16 + DFRAC)) / ad;
      if (tm > DMAX) tm = DMAX;
      if (td > DMAX) td = DMAX;
    end
  endtask

  // append the voxels that one ray enters to walk_q
  task automatic walk_ray(input ray_t r);
    longint      v[3];
    int          s[3];
    logic [63:0] tm[3], td[3];
    int          n, ax;
    voxel_t      e;
    axis_start(r.ox, r.dx, v[0], s[0], tm[0], td[0]);
    axis_start(r.oy, r.dy, v[1], s[1], tm[1], td[1]);
    axis_start(r.oz, r.dz, v[2], s[2], tm[2], td[2]);
    n = (r.cnt > MAX_STEPS) ? MAX_STEPS : r.cnt;
    for (int k = 0; k < n; k++) begin
      // ties go to z, then y
      if (tm[0] < tm[1]) ax = (tm[0] < tm[2]) ? 0 : 2;
      else               ax = (tm[1] < tm[2]) ? 1 : 2;
      v[ax] += s[ax];
      tm[ax] = tm[ax] + td[ax];
      if (tm[ax] > DMAX) tm[ax] = DMAX;
      e.vx = v[0][15:0];
      e.vy = v[1][15:0];
      e.vz = v[2][15:0];
      e.axis = (ax == 0) ? vrt_pkg::AXIS_X : (ax == 1) ? vrt_pkg::AXIS_Y : vrt_pkg::AXIS_Z;
      e.neg  = (s[ax] > 0);
      e.idx  = 7'(k + 1);
      e.last = (k + 1 == n);
      walk_q.push_back(e);
    end
  endtask

  function automatic logic signed [15:0] rand_dir();
    case ($urandom_range(0, 5))
      0:       return 16'sd0;
      1:       return 16'sd16384;
      2:       return -16'sd16384;
      3:       return 16'($urandom);                  // off the unit range
      default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
    endcase
  endfunction

  function automatic logic signed [23:0] rand_origin();
    case ($urandom_range(0, 4))
      0:       return 24'($urandom);
      1:       return 24'sd128 + 24'($urandom_range(0, 20) * 256) - 24'sd2560; // on faces
      default: return 24'($urandom_range(0, 16383)) - 24'sd8192;
    endcase
  endfunction

  function automatic ray_t mk(input logic signed [23:0] x, y, z,
                              input logic signed [15:0] a, b, c,
                              input logic [6:0] n);
    ray_t r;
    r = '{x, y, z, a, b, c, n};
    return r;
  endfunction

  initial begin
    ray_t r;
    // directed rays
    ray_q.push_back(mk(0, 0, 0, 16384, 0, 0, 5));
    ray_q.push_back(mk(0, 0, 0, 0, 0, 0, 4));                // all zero: walk -z
    ray_q.push_back(mk(0, 0, 0, 9459, 9459, 9459, 12));      // three-way ties
    ray_q.push_back(mk(128, -128, 128, 16384, -16384, 1, 6)); // origins on faces
    ray_q.push_back(mk(-128, 128, -128, -1, 1, -16384, 6));
    ray_q.push_back(mk(0, 0, 0, 1, -1, 0, 3));               // huge distances
    ray_q.push_back(mk(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16384, 16384, 16384, 64));
    ray_q.push_back(mk(24'h800000, 24'h800000, 24'h800000, -16384, -16384, -16384, 64));
    ray_q.push_back(mk(24'h7FFF80, 0, 24'h7FFF7F, 16384, 0, -16384, 3)); // wrap
    ray_q.push_back(mk(100, 200, -300, 16'h7FFF, 16'h8000, 16'hFFFF, 10));
    ray_q.push_back(mk(5, 6, 7, 8000, -12000, 9000, 0));     // no results
    ray_q.push_back(mk(5, 6, 7, 8000, -12000, 9000, 1));
    ray_q.push_back(mk(-7, 99, 1, -3000, 15000, -4000, 127)); // clamped
    ray_q.push_back(mk(-7, 99, 1, -3000, 15000, -4000, 65));
    ray_q.push_back(mk(24'h555555, 24'hAAAAAA, 24'h0F0F0F, 16'h5555, 16'hAAAA, 16'h0F0F, 64));
    for (int i = 0; i < N_RANDOM; i++) begin
      r.ox = rand_origin();
      r.oy = rand_origin();
      r.oz = rand_origin();
      r.dx = rand_dir();
      r.dy = rand_dir();
      r.dz = rand_dir();
      case ($urandom_range(0, 9))
        0:       r.cnt = 7'($urandom);
        1:       r.cnt = 7'($urandom_range(40, 64));
        default: r.cnt = 7'($urandom_range(1, 12));
      endcase
      ray_q.push_back(r);
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // sender: changes on the falling edge, holds until transfer
  always @(negedge clk) begin
    if (rst_n) begin
      quiet <= (n_rays >= 60 && n_rays < 100);
      if (in_valid && !in_fire) begin
        // hold
      end else begin
        if (in_valid) begin
          n_rays <= n_rays + 1;
          if (n_rays + 1 == 30) drain_hold <= 1'b1;
        end
        if (drain_hold && walk_q.size() == 0 && !in_valid) drain_hold <= 1'b0;
        if (ray_q.size() != 0 && !drain_hold && !(in_valid && n_rays + 1 == 30) &&
            (quiet || $urandom_range(0, 99) >= 37)) begin
          cur      <= ray_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (ray_q.size() == 0 && in_valid) stim_done <= 1'b1;
        end
      end
      out_ready <= quiet || ($urandom_range(0, 99) >= 37);
    end
  end

  // monitor: samples at the rising edge, predicts on ray transfer
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
      if (in_valid && in_ready) begin
        walk_ray(cur);
      end
      if (out_valid && out_ready) begin
        n_voxels <= n_voxels + 1;
        if (walk_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result %p", got);
        end else if (walk_q[0] !== got) begin
          errors <= errors + 1;
          if (errors < 10) $display("mismatch exp %p got %p", walk_q[0], got);
          void'(walk_q.pop_front());
        end else begin
          void'(walk_q.pop_front());
        end
      end
      if (idle_cnt > STALL_LIM) begin
        $display("timeout with %0d results pending", walk_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (walk_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d rays and %0d voxel steps, %0d mismatches",
             n_rays, n_voxels, errors);
    if (errors == 0 && walk_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== voxel_ray_traversal_top.f =====
hdl/vrt_pkg.sv
hdl/vrt_div.sv
hdl/vrt_datapath.sv
hdl/vrt_ctrl.sv
hdl/voxel_ray_traversal_top.sv
sim/tb_top.sv
